// ----- rtl/pnws_pkg.sv -----
// Package for the Perlin wind sampler: table geometry, register codes and
// the small arithmetic helpers shared by the datapath.
// No dependencies.
package pnws_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int COORD_W    = IDX_W + FRAC_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ONE        = 1 << FRAC_BITS;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COORD_SCALE   = 3'd0,
        REG_TIME_RATE     = 3'd1,
        REG_SECOND_OFFSET = 3'd2,
        REG_BASE_X        = 3'd3,
        REG_BASE_Y        = 3'd4,
        REG_GAIN_X        = 3'd5,
        REG_GAIN_Y        = 3'd6
    } cfg_reg_t;

    // diagonal gradient: +-u +-v, with x and y swapped when hash bit 1 is set
    function automatic logic signed [18:0] grad(input logic [7:0] h,
                                                input logic signed [17:0] dx,
                                                input logic signed [17:0] dy);
        logic signed [18:0] u;
        logic signed [18:0] v;
        u = h[1] ? 19'(dy) : 19'(dx);
        v = h[1] ? 19'(dx) : 19'(dy);
        if (h[0])
            u = -u;
        if (h[1])
            v = -v;
        return u + v;
    endfunction

    // a + floor(w * (b - a) / 2^F)
    function automatic logic signed [19:0] lerp(input logic signed [19:0] a,
                                                input logic signed [19:0] b,
                                                input logic signed [17:0] w);
        logic signed [38:0] diff;
        logic signed [38:0] prod;
        diff = 39'(b) - 39'(a);
        prod = 39'(w) * diff;
        return a + 20'(prod >>> FRAC_BITS);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767)
            return 16'sh7fff;
        if (v < -20'sd32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

endpackage

// ----- rtl/perlin_noise_wind_sampler_core.sv -----
// Wind sampler: two improved Perlin noise evaluations per sample item.
// A sample item's result strobe, done, comes from the last stage of the valid pipe.
// Throughput: one item per cycle, busy is never raised.
// The hash lookups read six replicated copies of the permutation table, two
// read ports each; load items write the first-level copies at stage 2 and the
// second-level copies at stage 3, keeping table updates in item order.
// Reset: asynchronous, clears pipeline valids and restores register defaults;
// the table itself holds no reset value. Results cannot be stalled.
module perlin_noise_wind_sampler_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            action,
    input  logic [7:0]                      perm_index,
    input  logic [7:0]                      perm_value,
    input  logic signed [15:0]              coord_x,
    input  logic signed [15:0]              coord_y,
    input  logic [31:0]                     time_value,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pnws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pnws_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            done,
    output logic signed [15:0]              wind_x,
    output logic signed [15:0]              wind_y,
    output logic signed [15:0]              noise_first,
    output logic signed [15:0]              noise_second
);
    import pnws_pkg::*;

    // configuration
    logic [15:0]        coord_scale_reg, time_rate_reg, gain_x_reg, gain_y_reg;
    logic [23:0]        second_offset_reg;
    logic signed [15:0] base_x_reg, base_y_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_scale_reg   <= 16'd8192;
            time_rate_reg     <= 16'd19661;
            second_offset_reg <= 24'd6553600;
            base_x_reg        <= 16'sd2048;
            base_y_reg        <= 16'sd0;
            gain_x_reg        <= 16'd26214;
            gain_y_reg        <= 16'd19661;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COORD_SCALE:   coord_scale_reg   <= cfg_data[15:0];
                REG_TIME_RATE:     time_rate_reg     <= cfg_data[15:0];
                REG_SECOND_OFFSET: second_offset_reg <= cfg_data;
                REG_BASE_X:        base_x_reg        <= cfg_data[15:0];
                REG_BASE_Y:        base_y_reg        <= cfg_data[15:0];
                REG_GAIN_X:        gain_x_reg        <= cfg_data[15:0];
                REG_GAIN_Y:        gain_y_reg        <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // valid pipe: samp_reg[k] marks a sample item in stage k, ld_reg a load item
    logic [11:1] samp_reg;
    logic [3:1]  ld_reg;
    logic        acc;

    assign acc = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samp_reg <= '0;
            ld_reg   <= '0;
        end
        else
        begin
            samp_reg <= {samp_reg[10:1], acc && (action == ACT_SAMPLE)};
            ld_reg   <= {ld_reg[2:1], acc && (action == ACT_LOAD)};
        end
    end

    // stage 1: captured item
    logic [IDX_W-1:0]   s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic [7:0]         s1_val_reg, s2_val_reg, s3_val_reg;
    logic signed [15:0] s1_x_reg, s1_y_reg;
    logic [31:0]        s1_t_reg;

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= perm_index[IDX_W-1:0];
        s1_val_reg <= perm_value;
        s1_x_reg   <= coord_x;
        s1_y_reg   <= coord_y;
        s1_t_reg   <= time_value;
        s2_idx_reg <= s1_idx_reg;
        s2_val_reg <= s1_val_reg;
        s3_idx_reg <= s2_idx_reg;
        s3_val_reg <= s2_val_reg;
    end

    // stage 2: scale products
    logic signed [32:0] s2_px_reg, s2_py_reg;
    logic [47:0]        s2_pt_reg;

    always_ff @(posedge clk)
    begin
        s2_px_reg <= 33'(s1_x_reg) * $signed({17'd0, coord_scale_reg});
        s2_py_reg <= 33'(s1_y_reg) * $signed({17'd0, coord_scale_reg});
        s2_pt_reg <= 48'(s1_t_reg) * 48'(time_rate_reg);
    end

    // wrapped noise coordinates; index 0 first noise, 1 second noise
    logic signed [22:0] px, py;
    logic [31:0]        tt;
    logic [COORD_W-1:0] cx [2];
    logic [COORD_W-1:0] cy [2];

    always_comb
    begin
        px    = 23'(s2_px_reg >>> (26 - FRAC_BITS));
        py    = 23'(s2_py_reg >>> (26 - FRAC_BITS));
        tt    = s2_pt_reg[32 - FRAC_BITS +: 32];
        cx[0] = COORD_W'(24'(px) + tt[23:0]);
        cy[0] = COORD_W'(24'(py));
        cx[1] = COORD_W'(24'(px) + second_offset_reg);
        cy[1] = COORD_W'(24'(py) + tt[23:0]);
    end

    // first-level table copies: one per noise, ports read P[xi] and P[xi+1]
    logic [7:0] mem_l1 [2][TABLE_SIZE];
    logic [7:0] l1_rd_reg [2][2];
    logic [FRAC_BITS-1:0] s3_f_reg [4];
    logic [IDX_W-1:0]     s3_yi_reg [2];

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 2; c++)
        begin
            if (ld_reg[2])
                mem_l1[c][s2_idx_reg] <= s2_val_reg;
            l1_rd_reg[c][0] <= mem_l1[c][cx[c][COORD_W-1:FRAC_BITS]];
            l1_rd_reg[c][1] <= mem_l1[c][cx[c][COORD_W-1:FRAC_BITS] + IDX_W'(1)];
            s3_f_reg[2*c]   <= cx[c][FRAC_BITS-1:0];
            s3_f_reg[2*c+1] <= cy[c][FRAC_BITS-1:0];
            s3_yi_reg[c]    <= cy[c][COORD_W-1:FRAC_BITS];
        end
    end

    // second-level copies: 2c hashes from P[xi], 2c+1 from P[xi+1]
    logic [7:0]       mem_l2 [4][TABLE_SIZE];
    logic [7:0]       l2_rd_reg [4][2];
    logic [IDX_W-1:0] l2_addr [4];

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            l2_addr[2*c]   = IDX_W'(l1_rd_reg[c][0]) + s3_yi_reg[c];
            l2_addr[2*c+1] = IDX_W'(l1_rd_reg[c][1]) + s3_yi_reg[c];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int m = 0; m < 4; m++)
        begin
            if (ld_reg[3])
                mem_l2[m][s3_idx_reg] <= s3_val_reg;
            l2_rd_reg[m][0] <= mem_l2[m][l2_addr[m]];
            l2_rd_reg[m][1] <= mem_l2[m][l2_addr[m] + IDX_W'(1)];
        end
    end

    // fade, first step (stage 3 -> 4): t2 and the inner polynomial
    logic [15:0]          s4_t2_reg [4];
    logic signed [21:0]   s4_q_reg [4];
    logic [FRAC_BITS-1:0] s4_f_reg [4];
    logic signed [21:0]   fm [4];
    logic signed [38:0]   fq [4];
    logic [31:0]          ff2 [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ff2[k] = 32'(s3_f_reg[k]) * 32'(s3_f_reg[k]);
            fm[k]  = $signed(22'(s3_f_reg[k]) * 22'd6) - 22'sd983040;
            fq[k]  = $signed({23'd0, s3_f_reg[k]}) * $signed({{17{fm[k][21]}}, fm[k]});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            s4_t2_reg[k] <= ff2[k][31:16];
            s4_q_reg[k]  <= 22'(fq[k] >>> FRAC_BITS);
            s4_f_reg[k]  <= s3_f_reg[k];
        end
    end

    // stage 4 -> 5: t3, p, and the eight corner gradients
    logic [15:0]        s5_t3_reg [4];
    logic [20:0]        s5_p_reg [4];
    logic signed [18:0] s5_g_reg [2][4];
    logic [31:0]        ft3 [4];
    logic signed [21:0] fp [4];
    logic signed [17:0] dx0 [2], dx1 [2], dy0 [2], dy1 [2];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ft3[k] = 32'(s4_t2_reg[k]) * 32'(s4_f_reg[k]);
            fp[k]  = s4_q_reg[k] + 22'sd655360;
        end
        for (int c = 0; c < 2; c++)
        begin
            dx0[c] = $signed({2'b00, s4_f_reg[2*c]});
            dy0[c] = $signed({2'b00, s4_f_reg[2*c+1]});
            dx1[c] = dx0[c] - 18'(ONE);
            dy1[c] = dy0[c] - 18'(ONE);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            s5_t3_reg[k] <= ft3[k][31:16];
            s5_p_reg[k]  <= fp[k][20:0];
        end
        for (int c = 0; c < 2; c++)
        begin
            s5_g_reg[c][0] <= grad(l2_rd_reg[2*c][0],   dx0[c], dy0[c]);
            s5_g_reg[c][1] <= grad(l2_rd_reg[2*c+1][0], dx1[c], dy0[c]);
            s5_g_reg[c][2] <= grad(l2_rd_reg[2*c][1],   dx0[c], dy1[c]);
            s5_g_reg[c][3] <= grad(l2_rd_reg[2*c+1][1], dx1[c], dy1[c]);
        end
    end

    // stage 5 -> 6: fade value
    logic signed [17:0] s6_fade_reg [4];
    logic signed [18:0] s6_g_reg [2][4];
    logic [36:0]        fprod [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            fprod[k] = 37'(s5_t3_reg[k]) * 37'(s5_p_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
            s6_fade_reg[k] <= $signed({1'b0, fprod[k][32:16]});
        s6_g_reg <= s5_g_reg;
    end

    // stage 6 -> 7: blend along x; stage 7 -> 8: blend along y
    logic signed [19:0] s7_r0_reg [2], s7_r1_reg [2];
    logic signed [17:0] s7_v_reg [2];
    logic signed [19:0] s8_n_reg [2];

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 2; c++)
        begin
            s7_r0_reg[c] <= lerp(20'(s6_g_reg[c][0]), 20'(s6_g_reg[c][1]),
                                 s6_fade_reg[2*c]);
            s7_r1_reg[c] <= lerp(20'(s6_g_reg[c][2]), 20'(s6_g_reg[c][3]),
                                 s6_fade_reg[2*c]);
            s7_v_reg[c]  <= s6_fade_reg[2*c+1];
            s8_n_reg[c]  <= lerp(s7_r0_reg[c], s7_r1_reg[c], s7_v_reg[c]);
        end
    end

    // stage 8 -> 9: Q1.14 noise; 9 -> 10: gain product; 10 -> 11: wind
    logic signed [15:0] s9_n_reg [2], s10_n_reg [2], s11_n_reg [2];
    logic signed [32:0] s10_prod_reg [2];
    logic signed [15:0] s11_w_reg [2];
    logic [15:0]        gain [2];
    logic signed [15:0] base [2];

    assign gain[0] = gain_x_reg;
    assign gain[1] = gain_y_reg;
    assign base[0] = base_x_reg;
    assign base[1] = base_y_reg;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 2; c++)
        begin
            s9_n_reg[c]     <= sat16(s8_n_reg[c] >>> (FRAC_BITS - 14));
            s10_prod_reg[c] <= 33'(s9_n_reg[c]) * $signed({17'd0, gain[c]});
            s10_n_reg[c]    <= s9_n_reg[c];
            s11_w_reg[c]    <= sat16(20'(base[c]) + 20'(s10_prod_reg[c] >>> 18));
            s11_n_reg[c]    <= s10_n_reg[c];
        end
    end

    assign done         = samp_reg[11];
    assign wind_x       = s11_w_reg[0];
    assign wind_y       = s11_w_reg[1];
    assign noise_first  = s11_n_reg[0];
    assign noise_second = s11_n_reg[1];

endmodule

// ----- sim/pnws_checker.sv -----
// Checker for the Perlin wind sampler: tracks table loads and register writes,
// predicts each sample item's wind and noise, and compares them with done strobes.
// Depends on pnws_pkg for register codes and action values.
module pnws_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               action,
    input  logic [7:0]         perm_index,
    input  logic [7:0]         perm_value,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    input  logic [31:0]        time_value,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               done,
    input  logic signed [15:0] wind_x,
    input  logic signed [15:0] wind_y,
    input  logic signed [15:0] noise_first,
    input  logic signed [15:0] noise_second,
    output int                 errors,
    output int                 pending,
    output int                 checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import pnws_pkg::*;

    typedef struct {
        logic signed [15:0] wx;
        logic signed [15:0] wy;
        logic signed [15:0] n1;
        logic signed [15:0] n2;
    } wind_t;

    wind_t       wind_q[$];
    logic [7:0]  perm_copy[256];
    logic [15:0] scale_r, rate_r, gx_r, gy_r;
    logic [23:0] offset_r;
    logic signed [15:0] bx_r, by_r;

    assign pending = wind_q.size();

    function automatic longint clamp16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint fade_q(input longint f);
        longint t2, t3, p;
        t2 = (f * f) >>> 16;
        t3 = (t2 * f) >>> 16;
        p = ((f * (6 * f - 15 * 65536)) >>> 16) + 10 * 65536;
        return (t3 * p) >>> 16;
    endfunction

    function automatic longint mix(input longint a, input longint b, input longint w);
        return a + ((w * (b - a)) >>> 16);
    endfunction

    function automatic longint slope(input logic [7:0] h, input longint dx, input longint dy);
        longint u, v;
        u = h[1] ? dy : dx;
        v = h[1] ? dx : dy;
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // noise at wrapped Q8.16 coordinates, result in Q1.14
    function automatic longint noise_at(input longint cx, input longint cy);
        logic [7:0] xi, yi, pa, pb, aa, ab, ba, bb;
        longint xf, yf, u, v, r0, r1;
        xi = 8'(cx >> 16);
        yi = 8'(cy >> 16);
        xf = cx & 65535;
        yf = cy & 65535;
        u = fade_q(xf);
        v = fade_q(yf);
        pa = perm_copy[xi];
        pb = perm_copy[8'(xi + 8'd1)];
        aa = perm_copy[8'(pa + yi)];
        ab = perm_copy[8'(pa + yi + 8'd1)];
        ba = perm_copy[8'(pb + yi)];
        bb = perm_copy[8'(pb + yi + 8'd1)];
        r0 = mix(slope(aa, xf, yf), slope(ba, xf - 65536, yf), u);
        r1 = mix(slope(ab, xf, yf - 65536), slope(bb, xf - 65536, yf - 65536), u);
        return clamp16(mix(r0, r1, v) >>> 2);
    endfunction

    function automatic wind_t predict_wind(input logic signed [15:0] x,
                                           input logic signed [15:0] y,
                                           input logic [31:0] t);
        longint px, py, tt, n1, n2;
        wind_t r;
        px = (longint'(x) * longint'(scale_r)) >>> 10;
        py = (longint'(y) * longint'(scale_r)) >>> 10;
        tt = (longint'(t) * longint'(rate_r)) >>> 16;
        n1 = noise_at((px + tt) & 24'hFFFFFF, py & 24'hFFFFFF);
        n2 = noise_at((px + longint'(offset_r)) & 24'hFFFFFF, (py + tt) & 24'hFFFFFF);
        r.n1 = 16'(n1);
        r.n2 = 16'(n2);
        r.wx = 16'(clamp16(longint'(bx_r) + ((n1 * longint'(gx_r)) >>> 18)));
        r.wy = 16'(clamp16(longint'(by_r) + ((n2 * longint'(gy_r)) >>> 18)));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        checked = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        wind_t e;
        if (!rst_n)
        begin
            scale_r = 16'd8192;
            rate_r = 16'd19661;
            offset_r = 24'd6553600;
            bx_r = 16'sd2048;
            by_r = 16'sd0;
            gx_r = 16'd26214;
            gy_r = 16'd19661;
            wind_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (wind_q.size() == 0)
                    report_mismatch("result strobes with nothing expected", 1, 0);
                else
                begin
                    e = wind_q.pop_front();
                    checked++;
                    if (wind_x !== e.wx) report_mismatch("wind_x", wind_x, e.wx);
                    if (wind_y !== e.wy) report_mismatch("wind_y", wind_y, e.wy);
                    if (noise_first !== e.n1) report_mismatch("noise_first", noise_first, e.n1);
                    if (noise_second !== e.n2)
                        report_mismatch("noise_second", noise_second, e.n2);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_COORD_SCALE:   scale_r = cfg_data[15:0];
                    REG_TIME_RATE:     rate_r = cfg_data[15:0];
                    REG_SECOND_OFFSET: offset_r = cfg_data;
                    REG_BASE_X:        bx_r = cfg_data[15:0];
                    REG_BASE_Y:        by_r = cfg_data[15:0];
                    REG_GAIN_X:        gx_r = cfg_data[15:0];
                    REG_GAIN_Y:        gy_r = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (action == ACT_LOAD)
                    perm_copy[perm_index] = perm_value;
                else
                    wind_q.push_back(predict_wind(coord_x, coord_y, time_value));
            end
        end
    end
endmodule

// ----- sim/tb_top.sv -----
// Top of the Perlin wind sampler testbench: clock, reset, item and register
// stimulus, watchdog and verdict. Depends on pnws_pkg, the core and pnws_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pnws_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN = 16;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               action = ACT_LOAD;
    logic [7:0]         perm_index = '0;
    logic [7:0]         perm_value = '0;
    logic signed [15:0] coord_x = '0;
    logic signed [15:0] coord_y = '0;
    logic [31:0]        time_value = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [23:0]        cfg_data = '0;
    logic               done;
    logic signed [15:0] wind_x, wind_y, noise_first, noise_second;
    int errors, pending, checked;
    int stall = 0;
    int n_items = 0, n_loads = 0, n_settings = 0;
    bit quiet = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    perlin_noise_wind_sampler_core dut (.*);

    pnws_checker chk (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall <= 0;
        else
        begin
            stall <= stall + 1;
            if (stall + 1 >= STALL_LIMIT)
            begin
                $display("watchdog expired after %0d quiet cycles", stall + 1);
                $display("perlin_noise_wind_sampler_core verification failed");
                $finish;
            end
        end
    end

    task automatic send(input logic act, input logic [7:0] idx, input logic [7:0] val,
                        input logic [15:0] x, input logic [15:0] y, input logic [31:0] t);
        action <= act;
        perm_index <= idx;
        perm_value <= val;
        coord_x <= x;
        coord_y <= y;
        time_value <= t;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        n_items++;
        if (act == ACT_LOAD)
            n_loads++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until all samples came back and in-flight loads have settled
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] sc, input logic [15:0] rt,
                            input logic [23:0] off, input logic [15:0] bx,
                            input logic [15:0] by, input logic [15:0] gx,
                            input logic [15:0] gy);
        settle();
        write_reg(REG_COORD_SCALE, 24'(sc));
        write_reg(REG_TIME_RATE, 24'(rt));
        write_reg(REG_SECOND_OFFSET, off);
        write_reg(REG_BASE_X, {8'hA5, bx});
        write_reg(REG_BASE_Y, 24'(by));
        write_reg(REG_GAIN_X, 24'(gx));
        write_reg(REG_GAIN_Y, 24'(gy));
        n_settings++;
    endtask

    task automatic random_item();
        logic [15:0] x, y;
        x = 16'($urandom);
        y = 16'($urandom);
        if ($urandom_range(0, 4) == 0)
        begin
            x = 16'($signed($urandom_range(0, 2047)) - 1024);
            y = 16'($signed($urandom_range(0, 2047)) - 1024);
        end
        if ($urandom_range(0, 6) == 0)
            send(ACT_LOAD, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), $urandom);
        else
            send(ACT_SAMPLE, 8'($urandom), 8'($urandom), x, y, $urandom);
    endtask

    initial
    begin
        logic [7:0] shuffle[256];
        logic [7:0] tmp;
        int j;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every table entry before any sample reads it
        for (int i = 0; i < 256; i++)
            shuffle[i] = 8'(i);
        for (int i = 255; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = shuffle[i];
            shuffle[i] = shuffle[j];
            shuffle[j] = tmp;
        end
        for (int i = 0; i < 256; i++)
            send(ACT_LOAD, 8'(i), shuffle[i], 16'($urandom), 16'($urandom), $urandom);

        // coordinate and time extremes at reset settings
        send(ACT_SAMPLE, 8'h00, 8'h00, 16'sh0000, 16'sh0000, 32'h0);
        send(ACT_SAMPLE, 8'hFF, 8'hFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF);
        send(ACT_SAMPLE, 8'h00, 8'h00, 16'sh8000, 16'sh8000, 32'h0);
        send(ACT_SAMPLE, 8'h00, 8'h00, 16'sh8000, 16'sh7FFF, 32'h0001_0000);
        send(ACT_SAMPLE, 8'h00, 8'h00, 16'sh7FFF, 16'sh8000, 32'h0000_0001);
        send(ACT_SAMPLE, 8'h00, 8'h00, 16'sh4000, 16'shC000, 32'h8000_0000);
        send(ACT_SAMPLE, 8'h00, 8'h00, 16'sh0001, 16'shFFFF, 32'h0000_FFFF);
        send(ACT_SAMPLE, 8'h00, 8'h00, 16'sh2000, 16'sh2000, 32'h0000_8000);
        // rewrites of two entries, then samples that read the updated table
        send(ACT_LOAD, 8'hFF, 8'h00, 16'sh0000, 16'sh0000, 32'h0);
        send(ACT_LOAD, 8'h00, 8'hFF, 16'sh0000, 16'sh0000, 32'h0);
        send(ACT_SAMPLE, 8'h00, 8'h00, 16'sh7FFF, 16'sh0000, 32'h0);
        send(ACT_SAMPLE, 8'h00, 8'h00, 16'sh0000, 16'sh7FFF, 32'h0);

        // hold off until the pipeline is empty before going on
        settle();

        set_regs(16'h0000, 16'h0000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        repeat (120) random_item();
        set_regs(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        repeat (120) random_item();
        set_regs(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
        repeat (120) random_item();
        settle();
        write_reg(3'd7, 24'($urandom));
        for (int p = 0; p < 3; p++)
        begin
            set_regs(16'($urandom), 16'($urandom), 24'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
            repeat (100) random_item();
        end
        set_regs(16'd8192, 16'd19661, 24'd6553600, 16'sd2048, 16'sd0, 16'd26214, 16'd19661);
        quiet = 1'b1;
        repeat (120) random_item();

        settle();
        $display("Covered %0d items (%0d table loads, %0d results checked) across %0d",
                 n_items, n_loads, checked, n_settings);
        $display("register settings, including all-zero, all-ones and signed extremes.");
        if (errors == 0 && pending == 0)
            $display("perlin_noise_wind_sampler_core verification clean");
        else
        begin
            if (pending != 0)
                $display("%0d expected results never arrived", pending);
            $display("perlin_noise_wind_sampler_core verification failed");
        end
        $finish;
    end
endmodule
